### rtl/core/tcct_pkg.sv
// shared types, constants and field layout for the tone candidate tracker
`timescale 1ns / 1ps

package tcct_pkg;

  localparam int CountWidth = 32;
  localparam int WideWidth  = CountWidth + 34;

  localparam int FreqWidth  = 17;
  localparam int QualWidth  = 16;
  localparam int WordWidth  = 32;
  localparam int AttWidth   = 8;
  localparam int CmdWidth   = 2;

  localparam int InDataWidth  = 168;
  localparam int OutDataWidth = 128;

  localparam int ApbAddrWidth = 5;
  localparam int ApbDataWidth = 32;

  localparam logic [ApbAddrWidth-1:0] RegFreqTol  = 5'd0;
  localparam logic [ApbAddrWidth-1:0] RegRearm    = 5'd4;
  localparam logic [ApbAddrWidth-1:0] RegMaxAtt   = 5'd8;
  localparam logic [ApbAddrWidth-1:0] RegRequired = 5'd12;
  localparam logic [ApbAddrWidth-1:0] RegRetry    = 5'd16;
  localparam logic [ApbAddrWidth-1:0] RegWinLen   = 5'd20;

  localparam logic [FreqWidth-1:0] FreqTolReset  = 17'd320;
  localparam logic [WordWidth-1:0] RearmReset    = 32'd8000;
  localparam logic [AttWidth-1:0]  MaxAttReset   = 8'd3;
  localparam logic [WordWidth-1:0] RequiredReset = 32'd800;
  localparam logic [WordWidth-1:0] RetryReset    = 32'd800;
  localparam logic [WordWidth-1:0] WinLenReset   = 32'd800;

  typedef enum logic [CmdWidth-1:0] {
    CmdObserve = 2'd0,
    CmdAccept  = 2'd1,
    CmdReject  = 2'd2,
    CmdWindow  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [FreqWidth-1:0] freq_tolerance;
    logic [WordWidth-1:0] rearm_count;
    logic [AttWidth-1:0]  max_attempts;
    logic [WordWidth-1:0] required_count;
    logic [WordWidth-1:0] retry_count;
    logic [WordWidth-1:0] window_length;
  } cfg_t;

  typedef struct packed {
    cmd_e                 cmd;
    logic [FreqWidth-1:0] tone_freq;
    logic [QualWidth-1:0] qualifying_count;
    logic                 continues_prev;
    logic [WordWidth-1:0] accept_start;
    logic [WordWidth-1:0] accept_end;
    logic [WordWidth-1:0] total_count;
    logic [WordWidth-1:0] history_count;
  } req_t;

  typedef struct packed {
    logic                 confirm_due;
    logic [WordWidth-1:0] window_end_point;
    logic                 is_active;
    logic [WordWidth-1:0] candidate_count;
    logic [WordWidth-1:0] confirmed_length;
    logic [AttWidth-1:0]  attempt_count;
    logic [FreqWidth-1:0] avg_freq;
  } rsp_t;

endpackage

### rtl/core/tcct_cfg_regs.sv
// apb configuration registers of the tone candidate tracker
`timescale 1ns / 1ps

module tcct_cfg_regs
  import tcct_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.freq_tolerance <= FreqTolReset;
      cfg_q.rearm_count    <= RearmReset;
      cfg_q.max_attempts   <= MaxAttReset;
      cfg_q.required_count <= RequiredReset;
      cfg_q.retry_count    <= RetryReset;
      cfg_q.window_length  <= WinLenReset;
    end else if (wr_en) begin
      case (paddr)
        RegFreqTol:  cfg_q.freq_tolerance <= pwdata[FreqWidth-1:0];
        RegRearm:    cfg_q.rearm_count    <= pwdata[WordWidth-1:0];
        RegMaxAtt:   cfg_q.max_attempts   <= pwdata[AttWidth-1:0];
        RegRequired: cfg_q.required_count <= pwdata[WordWidth-1:0];
        RegRetry:    cfg_q.retry_count    <= pwdata[WordWidth-1:0];
        RegWinLen:   cfg_q.window_length  <= pwdata[WordWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegFreqTol:  prdata = ApbDataWidth'(cfg_q.freq_tolerance);
      RegRearm:    prdata = ApbDataWidth'(cfg_q.rearm_count);
      RegMaxAtt:   prdata = ApbDataWidth'(cfg_q.max_attempts);
      RegRequired: prdata = ApbDataWidth'(cfg_q.required_count);
      RegRetry:    prdata = ApbDataWidth'(cfg_q.retry_count);
      RegWinLen:   prdata = ApbDataWidth'(cfg_q.window_length);
      default:     prdata = '0;
    endcase
  end

endmodule

### rtl/core/tcct_core.sv
// candidate state and single pass event logic of the tone candidate tracker
`timescale 1ns / 1ps

module tcct_core
  import tcct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic req_en_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  logic [CountWidth-1:0] st_q, st_d;
  logic [CountWidth-1:0] la_q, la_d;
  logic [WordWidth-1:0]  clen_q, clen_d;
  logic [WordWidth-1:0]  cfirst_q, cfirst_d;
  logic [WordWidth-1:0]  clast_q, clast_d;
  logic [WordWidth-1:0]  nwp_q, nwp_d;
  logic [FreqWidth-1:0]  frq_q, frq_d;
  logic                  act_q, act_d;
  logic [AttWidth-1:0]   att_q, att_d;

  // observe helpers
  logic [FreqWidth-1:0]  fdiff;
  logic [CountWidth-1:0] since_q;
  logic                  exhausted;
  logic                  restart;
  logic [CountWidth:0]   st_sum;
  logic [CountWidth-1:0] st_sat;
  logic [FreqWidth:0]    frq_sum;

  // accept helpers
  logic                  acc_disjoint;

  // window helpers
  logic [WideWidth-1:0]  st_w, tot_w, win_w;
  logic [WideWidth-1:0]  win_p;
  logic [WordWidth-1:0]  win_p_sat;
  logic                  win_first;
  logic                  win_proceed;
  logic [WordWidth-1:0]  win_pt;
  logic [WordWidth-1:0]  win_age;
  logic                  win_stale;
  logic [WordWidth-1:0]  win_endp;
  logic [WordWidth-1:0]  win_end;

  // due helpers
  logic [CountWidth-1:0] since_d;
  logic                  due;
  logic [CountWidth+WordWidth-1:0] cnt_ext;

  assign fdiff     = (req_i.tone_freq > frq_q) ? (req_i.tone_freq - frq_q)
                                                : (frq_q - req_i.tone_freq);
  assign since_q   = st_q - la_q;
  assign exhausted = (att_q >= cfg_i.max_attempts) &&
                     (WideWidth'(since_q) >= WideWidth'(cfg_i.rearm_count));
  assign restart   = !act_q || !req_i.continues_prev ||
                     (fdiff > cfg_i.freq_tolerance) || exhausted;
  assign st_sum    = {1'b0, st_q} + (CountWidth+1)'(req_i.qualifying_count);
  assign st_sat    = st_sum[CountWidth] ? '1 : st_sum[CountWidth-1:0];
  assign frq_sum   = {1'b0, frq_q} + {1'b0, req_i.tone_freq};

  assign acc_disjoint = (clen_q == '0) || (req_i.accept_start > clast_q) ||
                        (req_i.accept_end < cfirst_q);

  assign st_w      = WideWidth'(st_q);
  assign tot_w     = WideWidth'(req_i.total_count);
  assign win_w     = WideWidth'(cfg_i.window_length);
  assign win_p     = tot_w - st_w + win_w;
  assign win_p_sat = (win_p[WideWidth-1:WordWidth] != '0) ? '1 : win_p[WordWidth-1:0];
  assign win_first = (nwp_q == '0);
  assign win_proceed = (cfg_i.window_length != '0) &&
                       (req_i.history_count >= cfg_i.window_length) &&
                       (!win_first || !((st_w < win_w) || (st_w > tot_w)));
  assign win_pt    = win_first ? win_p_sat : nwp_q;
  assign win_age   = req_i.total_count - win_pt;
  assign win_stale = (win_pt < cfg_i.window_length) ||
                     (win_age > req_i.history_count) ||
                     (cfg_i.window_length > (req_i.history_count - win_age));
  assign win_endp  = win_stale ? req_i.total_count : win_pt;
  assign win_end   = (win_proceed && (req_i.total_count >= win_pt) &&
                      (win_endp >= cfg_i.window_length)) ? win_endp : '0;

  always_comb begin
    st_d     = st_q;
    la_d     = la_q;
    clen_d   = clen_q;
    cfirst_d = cfirst_q;
    clast_d  = clast_q;
    nwp_d    = nwp_q;
    frq_d    = frq_q;
    act_d    = act_q;
    att_d    = att_q;
    unique case (req_i.cmd)
      CmdObserve: begin
        if (req_i.qualifying_count == '0 || restart) begin
          st_d     = '0;
          la_d     = '0;
          clen_d   = '0;
          cfirst_d = '0;
          clast_d  = '0;
          nwp_d    = '0;
          frq_d    = '0;
          act_d    = 1'b0;
          att_d    = '0;
          if (req_i.qualifying_count != '0) begin
            st_d  = CountWidth'(req_i.qualifying_count);
            frq_d = req_i.tone_freq;
            act_d = 1'b1;
          end
        end else begin
          st_d  = st_sat;
          frq_d = frq_sum[FreqWidth:1];
        end
      end
      CmdAccept: begin
        if (req_i.accept_end > req_i.accept_start) begin
          if (acc_disjoint) begin
            cfirst_d = req_i.accept_start;
            clast_d  = req_i.accept_end;
          end else begin
            cfirst_d = (req_i.accept_start < cfirst_q) ? req_i.accept_start : cfirst_q;
            clast_d  = (req_i.accept_end > clast_q) ? req_i.accept_end : clast_q;
          end
          clen_d = clast_d - cfirst_d;
          att_d  = '0;
          la_d   = st_q;
        end
      end
      CmdReject: begin
        clen_d   = '0;
        cfirst_d = '0;
        clast_d  = '0;
        att_d    = (att_q != '1) ? att_q + 1'b1 : att_q;
        la_d     = st_q;
      end
      CmdWindow: begin
        if (win_proceed) begin
          nwp_d = win_pt;
        end
      end
      default: ;
    endcase
  end

  assign since_d = st_d - la_d;
  assign due = act_d &&
               (WideWidth'(st_d) >= WideWidth'(cfg_i.required_count)) &&
               (att_d < cfg_i.max_attempts) &&
               !((la_d != '0) &&
                 (WideWidth'(since_d) < WideWidth'(cfg_i.retry_count)));
  assign cnt_ext = {{WordWidth{1'b0}}, st_d};

  always_comb begin
    rsp_o.confirm_due      = due;
    rsp_o.window_end_point = (req_i.cmd == CmdWindow) ? win_end : '0;
    rsp_o.is_active        = act_d;
    rsp_o.candidate_count  = cnt_ext[WordWidth-1:0];
    rsp_o.confirmed_length = clen_d;
    rsp_o.attempt_count    = att_d;
    rsp_o.avg_freq         = frq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= '0;
      la_q     <= '0;
      clen_q   <= '0;
      cfirst_q <= '0;
      clast_q  <= '0;
      nwp_q    <= '0;
      frq_q    <= '0;
      act_q    <= 1'b0;
      att_q    <= '0;
    end else if (req_en_i) begin
      st_q     <= st_d;
      la_q     <= la_d;
      clen_q   <= clen_d;
      cfirst_q <= cfirst_d;
      clast_q  <= clast_d;
      nwp_q    <= nwp_d;
      frq_q    <= frq_d;
      act_q    <= act_d;
      att_q    <= att_d;
    end
  end

endmodule

### rtl/core/tone_candidate_confirmation_tracker.sv
// top level of the tone candidate tracker: input register, event logic, result register
//
//  channel  | dir | handshake                  | contents
//  s_axis   | in  | tvalid / tready            | one event request, kind in tuser
//  m_axis   | out | tvalid / tready            | one result per request
//  apb      | in  | psel / penable / pready    | six configuration registers
//
//  a request is held in the input register, then processed in one pass
//  and its result registered: result valid once it has passed the input and result registers,
//  one request per cycle sustained while m_axis accepts results
//  the rate is set by the candidate state update, which is read and written for each request
//  reset clears the candidate state and loads the register defaults
//  a stall on m_axis holds the result; the input register then refills and tready drops
`timescale 1ns / 1ps

module tone_candidate_confirmation_tracker
  import tcct_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // tone_freq, qualifying_count, continues_prev, accept_start, accept_end,
  // total_count, history_count, zero pad
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // cmd
  input  logic [CmdWidth-1:0]     s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // confirm_due, window_end_point, is_active, candidate_count, confirmed_length,
  // attempt_count, avg_freq, zero pad
  output logic [OutDataWidth-1:0] m_axis_tdata,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready
);

  cfg_t cfg;
  req_t req_q;
  rsp_t rsp;
  rsp_t rsp_q;
  logic in_vld_q;
  logic out_vld_q;
  logic advance;

  tcct_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tcct_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .req_en_i (advance),
    .req_i    (req_q),
    .rsp_o    (rsp)
  );

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_q.cmd              <= cmd_e'(s_axis_tuser);
      req_q.tone_freq        <= s_axis_tdata[16:0];
      req_q.qualifying_count <= s_axis_tdata[32:17];
      req_q.continues_prev   <= s_axis_tdata[33];
      req_q.accept_start     <= s_axis_tdata[65:34];
      req_q.accept_end       <= s_axis_tdata[97:66];
      req_q.total_count      <= s_axis_tdata[129:98];
      req_q.history_count    <= s_axis_tdata[161:130];
    end
    if (advance) begin
      rsp_q <= rsp;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0,
                          rsp_q.avg_freq,
                          rsp_q.attempt_count,
                          rsp_q.confirmed_length,
                          rsp_q.candidate_count,
                          rsp_q.is_active,
                          rsp_q.window_end_point,
                          rsp_q.confirm_due};

endmodule
